// ===== rtl/uartrb_pkg.sv =====
// Shared constants, types and pointer helpers for the UART ring buffers.
// No dependencies; imported by uartrb_ram and uart_rx_tx_ring_buffers_top.
package uartrb_pkg;

    localparam int BYTE_W   = 8;
    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;
    localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    typedef logic [RX_AW-1:0] rx_ptr_t;
    typedef logic [TX_AW-1:0] tx_ptr_t;

    typedef enum logic [S_TUSER_W-1:0] {
        KIND_LINE_RX  = 2'd0,
        KIND_TX_DONE  = 2'd1,
        KIND_HOST_RD  = 2'd2,
        KIND_HOST_WR  = 2'd3
    } kind_t;

    // Result word, first member is the top bits.
    typedef struct packed {
        logic [1:0]        pad;
        logic              tx_ready;
        logic              rx_nonempty;
        logic              tx_dropped;
        logic              rx_dropped;
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic [BYTE_W-1:0] line_byte;
        logic              line_send;
    } result_t;

    function automatic rx_ptr_t rx_adv(input rx_ptr_t p);
        return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic tx_ptr_t tx_adv(input tx_ptr_t p);
        return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ===== rtl/uartrb_ram.sv =====
// Simple dual-port byte RAM, one write and one registered read port.
// Depends on uartrb_pkg for the byte width.
module uartrb_ram #(
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [uartrb_pkg::BYTE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [uartrb_pkg::BYTE_W-1:0] rd_data
);
    import uartrb_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/uart_rx_tx_ring_buffers_top.sv =====
// UART receive/transmit ring buffers, top level.
// Depends on uartrb_pkg and uartrb_ram (one instance per queue).
//
// Usage:
//   Slave channel: one event per transfer. s_tuser carries the kind (line byte
//   received, transmit complete, host read, host write), s_tdata the byte.
//   Master channel: exactly one result transfer per event, in event order.
//   Each queue lives in its own synchronous RAM; pointers and the
//   transmitter-free flag are flops updated in the accept cycle, so the
//   next event sees them at once. A byte written in one cycle can be read
//   by the very next event, since its RAM read is issued in a later cycle.
// Pipeline: the accepting edge issues the RAM read and loads the read stage;
//   the output register loads from the read stage once it is free, and
//   m_tvalid rises with it.
// Throughput: one event per cycle while the output is not stalled, set by
//   the single RAM access per queue per event.
// Reset (aresetn low, synchronous): pointers cleared, both queues empty,
//   transmitter marked busy, pipeline and output emptied. Queue contents are
//   not cleared; only written entries are ever read.
// Stall: while m_tready is low the result register holds, one more event
//   is taken into an empty read stage, then s_tready drops until it drains.
module uart_rx_tx_ring_buffers_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [uartrb_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic [uartrb_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] line_send, [8:1] line_byte, [9] read_valid, [17:10] read_byte,
    // [18] rx_dropped, [19] tx_dropped, [20] rx_nonempty, [21] tx_ready,
    // [23:22] zero
    output logic [uartrb_pkg::M_TDATA_W-1:0] m_tdata
);
    import uartrb_pkg::*;

    // Queue pointers and transmitter state
    rx_ptr_t rx_wr_reg, rx_wr_next, rx_rd_reg, rx_rd_next;
    tx_ptr_t tx_wr_reg, tx_wr_next, tx_rd_reg, tx_rd_next;
    logic    tx_free_reg, tx_free_next;

    // Read stage: the event waiting on RAM data
    logic              st_valid_reg;
    logic              st_rx_rd_reg, st_rx_rd_next;   // read_byte from rx RAM
    logic              st_tx_rd_reg, st_tx_rd_next;   // line_byte from tx RAM
    logic              st_direct_reg, st_direct_next; // line_byte from host
    logic [BYTE_W-1:0] st_byte_reg;
    logic              st_rx_drop_reg, st_rx_drop_next;
    logic              st_tx_drop_reg, st_tx_drop_next;
    logic              st_rx_ne_reg, st_tx_rdy_reg;

    // Output register
    logic    out_valid_reg;
    result_t out_res_reg, out_res_next;

    logic              accept, out_free, st_move;
    kind_t             kind;
    logic [BYTE_W-1:0] din;
    logic              rx_empty, rx_full, tx_empty, tx_full;
    rx_ptr_t           rx_wr_adv, rx_rd_adv;
    tx_ptr_t           tx_wr_adv, tx_rd_adv;
    logic              rx_we, rx_re, tx_we, tx_re;
    logic [BYTE_W-1:0] rx_rdata, tx_rdata;

    assign kind     = kind_t'(s_tuser);
    assign din      = s_tdata[BYTE_W-1:0];
    assign out_free = !out_valid_reg || m_tready;
    assign st_move  = st_valid_reg && out_free;
    assign s_tready = !st_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    assign rx_wr_adv = rx_adv(rx_wr_reg);
    assign rx_rd_adv = rx_adv(rx_rd_reg);
    assign tx_wr_adv = tx_adv(tx_wr_reg);
    assign tx_rd_adv = tx_adv(tx_rd_reg);
    assign rx_empty  = (rx_wr_reg == rx_rd_reg);
    assign tx_empty  = (tx_wr_reg == tx_rd_reg);
    assign rx_full   = (rx_wr_adv == rx_rd_reg);
    assign tx_full   = (tx_wr_adv == tx_rd_reg);

    // Event decode: pointer updates and RAM accesses in the accept cycle
    always_comb begin
        rx_wr_next      = rx_wr_reg;
        rx_rd_next      = rx_rd_reg;
        tx_wr_next      = tx_wr_reg;
        tx_rd_next      = tx_rd_reg;
        tx_free_next    = tx_free_reg;
        rx_we           = 1'b0;
        rx_re           = 1'b0;
        tx_we           = 1'b0;
        tx_re           = 1'b0;
        st_rx_rd_next   = 1'b0;
        st_tx_rd_next   = 1'b0;
        st_direct_next  = 1'b0;
        st_rx_drop_next = 1'b0;
        st_tx_drop_next = 1'b0;
        if (accept) begin
            unique case (kind)
                KIND_LINE_RX: begin
                    if (rx_full) begin
                        st_rx_drop_next = 1'b1;
                    end else begin
                        rx_we      = 1'b1;
                        rx_wr_next = rx_wr_adv;
                    end
                end
                KIND_TX_DONE: begin
                    if (!tx_empty) begin
                        tx_re         = 1'b1;
                        st_tx_rd_next = 1'b1;
                        tx_rd_next    = tx_rd_adv;
                    end else begin
                        tx_free_next = 1'b1;
                    end
                end
                KIND_HOST_RD: begin
                    if (!rx_empty) begin
                        rx_re         = 1'b1;
                        st_rx_rd_next = 1'b1;
                        rx_rd_next    = rx_rd_adv;
                    end
                end
                KIND_HOST_WR: begin
                    if (tx_free_reg) begin
                        tx_free_next   = 1'b0;
                        st_direct_next = 1'b1;
                    end else if (tx_full) begin
                        st_tx_drop_next = 1'b1;
                    end else begin
                        tx_we      = 1'b1;
                        tx_wr_next = tx_wr_adv;
                    end
                end
                default: ;
            endcase
        end
    end

    uartrb_ram #(.DEPTH(RX_DEPTH)) u_rx_ram (
        .aclk    (aclk),
        .wr_en   (rx_we),
        .wr_addr (rx_wr_reg),
        .wr_data (din),
        .rd_en   (rx_re),
        .rd_addr (rx_rd_reg),
        .rd_data (rx_rdata)
    );

    uartrb_ram #(.DEPTH(TX_DEPTH)) u_tx_ram (
        .aclk    (aclk),
        .wr_en   (tx_we),
        .wr_addr (tx_wr_reg),
        .wr_data (din),
        .rd_en   (tx_re),
        .rd_addr (tx_rd_reg),
        .rd_data (tx_rdata)
    );

    // Result assembly once RAM data is out
    always_comb begin
        out_res_next             = '0;
        out_res_next.line_send   = st_tx_rd_reg || st_direct_reg;
        out_res_next.line_byte   = st_tx_rd_reg  ? tx_rdata :
                                   st_direct_reg ? st_byte_reg : '0;
        out_res_next.read_valid  = st_rx_rd_reg;
        out_res_next.read_byte   = st_rx_rd_reg ? rx_rdata : '0;
        out_res_next.rx_dropped  = st_rx_drop_reg;
        out_res_next.tx_dropped  = st_tx_drop_reg;
        out_res_next.rx_nonempty = st_rx_ne_reg;
        out_res_next.tx_ready    = st_tx_rdy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_wr_reg     <= '0;
            rx_rd_reg     <= '0;
            tx_wr_reg     <= '0;
            tx_rd_reg     <= '0;
            tx_free_reg   <= 1'b0;
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rx_wr_reg   <= rx_wr_next;
            rx_rd_reg   <= rx_rd_next;
            tx_wr_reg   <= tx_wr_next;
            tx_rd_reg   <= tx_rd_next;
            tx_free_reg <= tx_free_next;
            if (accept) begin
                st_valid_reg <= 1'b1;
            end else if (st_move) begin
                st_valid_reg <= 1'b0;
            end
            if (st_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            st_rx_rd_reg   <= st_rx_rd_next;
            st_tx_rd_reg   <= st_tx_rd_next;
            st_direct_reg  <= st_direct_next;
            st_byte_reg    <= din;
            st_rx_drop_reg <= st_rx_drop_next;
            st_tx_drop_reg <= st_tx_drop_next;
            st_rx_ne_reg   <= (rx_wr_next != rx_rd_next);
            st_tx_rdy_reg  <= tx_free_next;
        end
        if (st_move) begin
            out_res_reg <= out_res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

    // One event never both sends to the line and returns a host byte
    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_res_reg.line_send && out_res_reg.read_valid))
        else $error("line send and host read in one result");

    // A receive drop only happens with a full, hence nonempty, queue
    a_rx_drop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.rx_dropped) |-> out_res_reg.rx_nonempty)
        else $error("rx drop reported with empty receive queue");

    // A transmit drop means the write was not sent directly
    a_tx_drop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.tx_dropped) |->
            (!out_res_reg.tx_ready && !out_res_reg.line_send))
        else $error("tx drop while transmitter free or sending");

    // Read stage never holds RAM data that the next access would clobber
    a_no_read_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid_reg && !out_free) |-> !(rx_re || tx_re))
        else $error("RAM read issued while read stage stalled");

endmodule
